>>> design/nps_pkg.sv
// nps_pkg: types and constants for the non-preemptive priority scheduler
// used by nonpreemptive_priority_scheduler and its port checker; no dependencies
package nps_pkg;

	localparam int unsigned MAX_JOBS_DEF = 64;
	localparam int unsigned ID_W         = 8;
	localparam int unsigned ARR_W        = 16;
	localparam int unsigned BURST_W      = 16;
	localparam int unsigned PRIO_W       = 8;
	localparam int unsigned TIME_W       = 23;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	typedef struct packed {
		logic [ID_W-1:0]    job_id;
		logic [ARR_W-1:0]   arrival_time;
		logic [BURST_W-1:0] burst_length;
		logic [PRIO_W-1:0]  priority_level;
		logic               last_job;
	} job_word_t;

	typedef struct packed {
		logic [ID_W-1:0]   sched_id;
		logic [TIME_W-1:0] start_time;
		logic [TIME_W-1:0] finish_time;
		logic [TIME_W-1:0] waiting_time;
		logic [TIME_W-1:0] turnaround_time;
		logic              last_result;
	} res_word_t;

	// one row of the job table
	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [ARR_W-1:0]   arr;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
	} job_entry_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_OUT
	} state_t;

endpackage

>>> design/nonpreemptive_priority_scheduler.sv
// Non-preemptive priority scheduler. Jobs are loaded one word per cycle while
// job_stall is low into a table of MAX_JOBS rows; the word with last_job set
// (stored if there is room) starts the schedule, and jobs beyond the table size
// are dropped. Each dispatch scans every loaded row through the table's single
// read port, then a drain and a decide state pick the job, and the result word
// is held until taken. The job side is stalled from the last job until the
// result word flagged last_result has been taken. Times saturate at 2^23 - 1.
// Depends on nps_pkg.
module nonpreemptive_priority_scheduler #(
	parameter int unsigned MAX_JOBS = nps_pkg::MAX_JOBS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	output logic                job_stall,
	input  nps_pkg::job_word_t  job,
	output logic                res_valid,
	input  logic                res_stall,
	output nps_pkg::res_word_t  res
);
	import nps_pkg::*;

	localparam int unsigned IDX_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_JOBS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_JOBS);

	state_t state_q, state_d;

	job_entry_t mem_q [MAX_JOBS];

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    disp_q;
	logic [TIME_W-1:0]   time_q;
	logic [IDX_W-1:0]    rd_idx_q;
	logic [MAX_JOBS-1:0] done_q;

	job_entry_t       ent_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             vld_s1;

	// best job that has already arrived
	logic             best_vld_q;
	job_entry_t       best_q;
	logic [IDX_W-1:0] best_idx_q;
	// best among the earliest pending arrivals
	logic             min_vld_q;
	job_entry_t       min_q;
	logic [IDX_W-1:0] min_idx_q;

	res_word_t res_q;
	logic      res_valid_q;

	logic job_accept, load_we, res_accept, last_rd, scan_start;
	logic pend, arrived, best_upd, min_upd;

	job_entry_t         pick;
	logic [IDX_W-1:0]   pick_idx;
	logic [TIME_W-1:0]  start_t, finish_t;
	logic [TIME_W:0]    sum_t;

	assign job_accept = job_valid && !job_stall;
	assign load_we    = job_accept && (count_q < CNT_MAX);
	assign res_accept = res_valid_q && !res_stall;
	assign last_rd    = (rd_idx_q == IDX_W'(count_q - 1'b1));

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// compare unit on the word read back from the table
	always_comb begin
		pend     = vld_s1 && !done_q[idx_s1];
		arrived  = (TIME_W'(ent_s1.arr) <= time_q);
		best_upd = pend && arrived && (!best_vld_q || (ent_s1.prio < best_q.prio) ||
			((ent_s1.prio == best_q.prio) && (ent_s1.arr < best_q.arr)));
		min_upd  = pend && (!min_vld_q || (ent_s1.arr < min_q.arr) ||
			((ent_s1.arr == min_q.arr) && (ent_s1.prio < min_q.prio)));
	end

	// dispatch arithmetic
	always_comb begin
		if (best_vld_q) begin
			pick     = best_q;
			pick_idx = best_idx_q;
			start_t  = time_q;
		end else begin
			pick     = min_q;
			pick_idx = min_idx_q;
			start_t  = TIME_W'(min_q.arr);
		end
		sum_t    = {1'b0, start_t} + (TIME_W + 1)'(pick.burst);
		finish_t = sum_t[TIME_W] ? TIME_MAX : sum_t[TIME_W-1:0];
	end

	always_comb begin
		state_d    = state_q;
		job_stall  = 1'b1;
		scan_start = 1'b0;
		case (state_q)
			ST_LOAD: begin
				job_stall = 1'b0;
				if (job_accept && job.last_job) begin
					state_d    = ST_SCAN;
					scan_start = 1'b1;
				end
			end
			ST_SCAN: begin
				if (last_rd) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (res_accept) begin
					if (disp_q == count_q) begin
						state_d = ST_LOAD;
					end else begin
						state_d    = ST_SCAN;
						scan_start = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// job table: one write port for loading, one registered read port for the scan
	always_ff @(posedge clk) begin
		if (load_we) begin
			mem_q[count_q[IDX_W-1:0]] <= '{id: job.job_id, arr: job.arrival_time,
				burst: job.burst_length, prio: job.priority_level};
		end
		ent_s1 <= mem_q[rd_idx_q];
		idx_s1 <= rd_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			disp_q      <= '0;
			time_q      <= '0;
			rd_idx_q    <= '0;
			done_q      <= '0;
			vld_s1      <= 1'b0;
			best_vld_q  <= 1'b0;
			min_vld_q   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (load_we) begin
				count_q <= count_q + 1'b1;
			end
			vld_s1 <= (state_q == ST_SCAN);
			if (state_q == ST_SCAN) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (best_upd) begin
				best_vld_q <= 1'b1;
			end
			if (min_upd) begin
				min_vld_q <= 1'b1;
			end
			if (scan_start) begin
				rd_idx_q   <= '0;
				best_vld_q <= 1'b0;
				min_vld_q  <= 1'b0;
				if (state_q == ST_LOAD) begin
					done_q <= '0;
					disp_q <= '0;
					time_q <= '0;
				end
			end
			if (state_q == ST_DECIDE) begin
				done_q[pick_idx] <= 1'b1;
				disp_q           <= disp_q + 1'b1;
				time_q           <= finish_t;
				res_valid_q      <= 1'b1;
			end
			if (res_accept) begin
				res_valid_q <= 1'b0;
				if (disp_q == count_q) begin
					count_q <= '0;
					time_q  <= '0;
				end
			end
		end
	end

	// candidate payload and result word
	always_ff @(posedge clk) begin
		if (best_upd) begin
			best_q     <= ent_s1;
			best_idx_q <= idx_s1;
		end
		if (min_upd) begin
			min_q     <= ent_s1;
			min_idx_q <= idx_s1;
		end
		if (state_q == ST_DECIDE) begin
			res_q.sched_id        <= pick.id;
			res_q.start_time      <= start_t;
			res_q.finish_time     <= finish_t;
			res_q.waiting_time    <= start_t - TIME_W'(pick.arr);
			res_q.turnaround_time <= finish_t - TIME_W'(pick.arr);
			res_q.last_result     <= (CNT_W'(disp_q + 1'b1) == count_q);
		end
	end

endmodule

>>> design/nps_checker.sv
// nps_checker: port-level checks for nonpreemptive_priority_scheduler
// bound to the top level below; depends on nps_pkg
module nps_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               job_valid,
	input logic               job_stall,
	input nps_pkg::job_word_t job,
	input logic               res_valid,
	input logic               res_stall,
	input nps_pkg::res_word_t res
);
	import nps_pkg::*;

	// a stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("result word changed while stalled");

	// no job is taken while a result is pending
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> job_stall)
		else $error("job side open while result pending");

	// the last job closes the job side
	a_last_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid && !job_stall && job.last_job |=> job_stall)
		else $error("job side still open after last job");

	// the final result reopens the job side
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && res.last_result |=> !job_stall)
		else $error("job side not reopened after last result");

	// turnaround is run time plus waiting time
	a_times: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.turnaround_time ==
			TIME_W'(res.finish_time - res.start_time + res.waiting_time)))
		else $error("inconsistent result times");

endmodule

bind nonpreemptive_priority_scheduler nps_checker u_nps_checker (.*);
